// ===== design/fmiq_pkg.sv =====
// fmiq_pkg: shared types, constants and the sine table builder for the FM I/Q modulator.
// Used by every module of the block; depends on nothing.

package fmiq_pkg;

    // widths of the stream fields and registers
    localparam int SAMPLE_W = 18;
    localparam int GAIN_W   = 24;
    localparam int AMP_W    = 7;
    localparam int COUNT_W  = 7;
    localparam int PHASE_W  = 32;
    localparam int IQ_W     = 8;
    localparam int ROM_W    = 16;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;

    // repeat limit and quarter-wave table size
    localparam int MAX_INTERP      = 64;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int TABLE_STEPS     = 1 << TABLE_ADDR_BITS;
    localparam int ROM_ADDR_W      = TABLE_ADDR_BITS + 1;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLEVEL_W    = $clog2(QUEUE_DEPTH + 1);

    // full-scale audio in Q2.15
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_POS_LIMIT = SAMPLE_W'(32768);
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_NEG_LIMIT = -SAMPLE_W'(32768);

    // register reset values
    localparam logic [GAIN_W-1:0]  PHASE_GAIN_RST   = GAIN_W'(3758096);
    localparam logic [AMP_W-1:0]   AMPLITUDE_RST    = AMP_W'(100);
    localparam logic [COUNT_W-1:0] INTERP_RATIO_RST = COUNT_W'(50);

    // pi/2 in Q30
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

    typedef enum logic [1:0] {
        REQ_START   = 2'd0,
        REQ_SILENCE = 2'd1,
        REQ_AUDIO   = 2'd2
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_GAIN   = 2'd0,
        CFG_AMPLITUDE    = 2'd1,
        CFG_INTERP_RATIO = 2'd2
    } cfg_index_t;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_EMIT  = 1'b1
    } cmd_kind_t;

    // one classified request, as queued for the back end
    typedef struct packed {
        cmd_kind_t          kind;
        logic [PHASE_W-1:0] step;
        logic [COUNT_W-1:0] count;
    } cmd_t;

    // sequencer state seen by the top level
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [COUNT_W-1:0] remain;
    } back_status_t;

    typedef logic [ROM_W-1:0] rom_t [0:TABLE_STEPS];

    // unsigned quotient by shift and subtract, for the table builder
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quot;
        logic [64:0] rem;
        int          b;
        quot = '0;
        rem  = '0;
        for (b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem     = rem - {1'b0, den};
                quot[b] = 1'b1;
            end
        end
        return quot;
    endfunction

    // sin(pi/2 * k / TABLE_STEPS) in Q15 via a Q30 Taylor series, rounded half up
    function automatic logic [ROM_W-1:0] rom_entry(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        divisor;
        logic signed [63:0] sum;
        logic [63:0]        r;
        int unsigned        n;
        x    = (PI_HALF_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (n = 1; n < 12; n++)
        begin
            term    = (term * x2) >> 30;
            divisor = 64'(2 * n) * 64'(2 * n + 1);
            term    = udiv64(term, divisor);
            if (n[0])
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 64'sd0;
        if (unsigned'(sum) > Q30_ONE)
            sum = signed'(Q30_ONE);
        r = (unsigned'(sum) + 64'd16384) >> 15;
        return r[ROM_W-1:0];
    endfunction

    function automatic rom_t build_sine_rom();
        rom_t        rom;
        int unsigned k;
        for (k = 0; k <= TABLE_STEPS; k++)
        begin
            rom[k] = rom_entry(k);
        end
        return rom;
    endfunction

endpackage

// ===== design/fmiq_front.sv =====
// fmiq_front: takes requests off the input stream, clamps audio, works out the phase step
// and the repeat count, and queues one command per known request. Depends on fmiq_pkg.

module fmiq_front
(
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [23:0]                        s_tdata,   // [17:0] audio_sample
    input  logic [1:0]                         s_tuser,   // [1:0] req_type
    input  logic [fmiq_pkg::GAIN_W-1:0]        phase_gain,
    input  logic [fmiq_pkg::COUNT_W-1:0]       interp_ratio,
    input  logic                               q_full,
    output logic                               q_push,
    output fmiq_pkg::cmd_t                     q_entry
);

    logic signed [fmiq_pkg::SAMPLE_W-1:0]                      sample_raw;
    logic signed [fmiq_pkg::SAMPLE_W-1:0]                      sample_clamped;
    logic signed [fmiq_pkg::GAIN_W+fmiq_pkg::SAMPLE_W:0]       product;
    logic signed [fmiq_pkg::GAIN_W+fmiq_pkg::SAMPLE_W:0]       product_shr;
    logic [fmiq_pkg::COUNT_W-1:0]                              count;
    logic                                                      known;

    // clamp to +/- full scale
    always_comb
    begin
        sample_raw = signed'(s_tdata[fmiq_pkg::SAMPLE_W-1:0]);
        if (sample_raw > fmiq_pkg::SAMPLE_POS_LIMIT)
            sample_clamped = fmiq_pkg::SAMPLE_POS_LIMIT;
        else if (sample_raw < fmiq_pkg::SAMPLE_NEG_LIMIT)
            sample_clamped = fmiq_pkg::SAMPLE_NEG_LIMIT;
        else
            sample_clamped = sample_raw;
    end

    // phase step: floor(gain * sample / 2^15), kept modulo 2^32
    assign product     = signed'({1'b0, phase_gain}) * sample_clamped;
    assign product_shr = product >>> 15;

    // repeat count: zero counts as one, capped at the interpolation limit
    always_comb
    begin
        if (interp_ratio == '0)
            count = fmiq_pkg::COUNT_W'(1);
        else if (interp_ratio > fmiq_pkg::COUNT_W'(fmiq_pkg::MAX_INTERP))
            count = fmiq_pkg::COUNT_W'(fmiq_pkg::MAX_INTERP);
        else
            count = interp_ratio;
    end

    // classify the request
    always_comb
    begin
        known         = 1'b1;
        q_entry.kind  = fmiq_pkg::CMD_EMIT;
        q_entry.step  = '0;
        q_entry.count = fmiq_pkg::COUNT_W'(1);
        case (fmiq_pkg::req_type_t'(s_tuser))
            fmiq_pkg::REQ_START:
            begin
                q_entry.kind = fmiq_pkg::CMD_START;
            end
            fmiq_pkg::REQ_SILENCE:
            begin
                q_entry.kind = fmiq_pkg::CMD_EMIT;
            end
            fmiq_pkg::REQ_AUDIO:
            begin
                q_entry.step  = product_shr[fmiq_pkg::PHASE_W-1:0];
                q_entry.count = count;
            end
            default:
            begin
                // unknown type: taken and dropped
                known = 1'b0;
            end
        endcase
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && known;

endmodule

// ===== design/fmiq_queue.sv =====
// fmiq_queue: short command queue between the front and back ends.
// Depends on fmiq_pkg.

module fmiq_queue
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  fmiq_pkg::cmd_t                    entry_in,
    input  logic                              pop,
    output logic                              full,
    output logic                              not_empty,
    output fmiq_pkg::cmd_t                    entry_out,
    output logic [fmiq_pkg::QLEVEL_W-1:0]     level
);

    fmiq_pkg::cmd_t                   slots [0:fmiq_pkg::QUEUE_DEPTH-1];
    logic [fmiq_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [fmiq_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [fmiq_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [fmiq_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [fmiq_pkg::QLEVEL_W-1:0]    level_reg;
    logic [fmiq_pkg::QLEVEL_W-1:0]    level_next;
    logic                             do_push;
    logic                             do_pop;

    assign full      = (level_reg == fmiq_pkg::QLEVEL_W'(fmiq_pkg::QUEUE_DEPTH));
    assign not_empty = (level_reg != '0);
    assign level     = level_reg;
    assign entry_out = slots[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            level_next = level_reg + 1'b1;
        else if (do_pop && !do_push)
            level_next = level_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= entry_in;
    end

endmodule

// ===== design/fmiq_back.sv =====
// fmiq_back: phase sequencer, sine table lookup and amplitude scaling, ending in the
// output register of the result stream. Depends on fmiq_pkg.

module fmiq_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  fmiq_pkg::cmd_t                    q_entry,
    output logic                              q_pop,
    input  logic [fmiq_pkg::AMP_W-1:0]        amplitude,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // [7:0] i_value, [15:8] q_value
    output logic                              m_tlast,
    output fmiq_pkg::back_status_t            status
);

    localparam fmiq_pkg::rom_t SINE_ROM = fmiq_pkg::build_sine_rom();

    logic                                 adv;
    logic [fmiq_pkg::PHASE_W-1:0]         phase_reg;
    logic [fmiq_pkg::PHASE_W-1:0]         phase_next;
    logic [fmiq_pkg::PHASE_W-1:0]         step_reg;
    logic [fmiq_pkg::PHASE_W-1:0]         step_next;
    logic [fmiq_pkg::COUNT_W-1:0]         remain_reg;
    logic [fmiq_pkg::COUNT_W-1:0]         remain_next;
    logic                                 emit;
    logic                                 emit_last;

    logic                                 s1_valid_reg;
    logic                                 s1_last_reg;

    logic [1:0]                           quad_sin;
    logic [1:0]                           quad_cos;
    logic [fmiq_pkg::ROM_ADDR_W-1:0]      addr_sin;
    logic [fmiq_pkg::ROM_ADDR_W-1:0]      addr_cos;
    logic                                 s2_valid_reg;
    logic                                 s2_last_reg;
    logic [fmiq_pkg::ROM_W-1:0]           rom_sin_reg;
    logic [fmiq_pkg::ROM_W-1:0]           rom_cos_reg;
    logic                                 neg_sin_reg;
    logic                                 neg_cos_reg;

    logic                                 out_valid_reg;
    logic                                 out_last_reg;
    logic [fmiq_pkg::IQ_W-1:0]            i_reg;
    logic [fmiq_pkg::IQ_W-1:0]            q_reg;

    // odd quadrants read the table backwards
    function automatic logic [fmiq_pkg::ROM_ADDR_W-1:0] table_addr(
        input logic [1:0]                             quad,
        input logic [fmiq_pkg::TABLE_ADDR_BITS-1:0]   idx
    );
        logic [fmiq_pkg::ROM_ADDR_W-1:0] wide_idx;
        wide_idx = {1'b0, idx};
        if (quad[0])
            return fmiq_pkg::ROM_ADDR_W'(fmiq_pkg::TABLE_STEPS) - wide_idx;
        else
            return wide_idx;
    endfunction

    // amplitude * table / 2^15, rounded half away from zero
    function automatic logic [fmiq_pkg::IQ_W-1:0] scale(
        input logic [fmiq_pkg::AMP_W-1:0]   amp,
        input logic [fmiq_pkg::ROM_W-1:0]   mag,
        input logic                         neg
    );
        logic [fmiq_pkg::AMP_W+fmiq_pkg::ROM_W-1:0] prod;
        logic [fmiq_pkg::IQ_W-1:0]                  r;
        prod = fmiq_pkg::AMP_W'(amp) * mag;
        prod = prod + (fmiq_pkg::AMP_W + fmiq_pkg::ROM_W)'(16384);
        r    = prod[fmiq_pkg::AMP_W+fmiq_pkg::ROM_W-1:15];
        return neg ? (~r + 1'b1) : r;
    endfunction

    // the whole back end moves only when the output register can take a new pair
    assign adv = !out_valid_reg || m_tready;

    // sequencer: one phase step per cycle while a command runs and the output is not stalled
    always_comb
    begin
        phase_next  = phase_reg;
        step_next   = step_reg;
        remain_next = remain_reg;
        emit        = 1'b0;
        emit_last   = 1'b0;
        q_pop       = 1'b0;
        if (adv)
        begin
            if (remain_reg != '0)
            begin
                phase_next  = phase_reg + step_reg;
                remain_next = remain_reg - 1'b1;
                emit        = 1'b1;
                emit_last   = (remain_reg == fmiq_pkg::COUNT_W'(1));
            end
            else if (q_valid)
            begin
                q_pop = 1'b1;
                case (q_entry.kind)
                    fmiq_pkg::CMD_START:
                    begin
                        phase_next = '0;
                    end
                    fmiq_pkg::CMD_EMIT:
                    begin
                        phase_next  = phase_reg + q_entry.step;
                        step_next   = q_entry.step;
                        remain_next = q_entry.count - 1'b1;
                        emit        = 1'b1;
                        emit_last   = (q_entry.count == fmiq_pkg::COUNT_W'(1));
                    end
                    default:
                    begin
                        q_pop = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            remain_reg   <= '0;
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            if (adv)
            begin
                s1_valid_reg <= emit;
                s1_last_reg  <= emit_last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
    end

    // table addresses; cosine is the sine a quarter turn on
    assign quad_sin = phase_reg[fmiq_pkg::PHASE_W-1 -: 2];
    assign quad_cos = quad_sin + 2'd1;
    assign addr_sin = table_addr(quad_sin,
                                 phase_reg[fmiq_pkg::PHASE_W-3 -: fmiq_pkg::TABLE_ADDR_BITS]);
    assign addr_cos = table_addr(quad_cos,
                                 phase_reg[fmiq_pkg::PHASE_W-3 -: fmiq_pkg::TABLE_ADDR_BITS]);

    // table read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rom_sin_reg <= SINE_ROM[addr_sin];
            rom_cos_reg <= SINE_ROM[addr_cos];
            neg_sin_reg <= quad_sin[1];
            neg_cos_reg <= quad_cos[1];
        end
    end

    // scaling into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s2_valid_reg;
            out_last_reg  <= s2_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i_reg <= scale(amplitude, rom_cos_reg, neg_cos_reg);
            q_reg <= scale(amplitude, rom_sin_reg, neg_sin_reg);
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign m_tlast       = out_last_reg;
    assign m_tdata       = {q_reg, i_reg};
    assign status.phase  = phase_reg;
    assign status.remain = remain_reg;

endmodule

// ===== design/fm_iq_modulator.sv =====
// fm_iq_modulator: top level of the FM I/Q modulator; holds the configuration registers.
// Instantiates fmiq_front, fmiq_queue and fmiq_back; depends on fmiq_pkg.

// A request carries req_type on s_tuser and a Q2.15 audio value on s_tdata. A start request
// clears the carrier phase and gives nothing; a silence request gives one I/Q pair at the
// current phase; an audio request gives interp_ratio pairs (zero counts as one, capped at 64),
// the phase advancing by floor(phase_gain*sample/2^15) before each pair. The last pair of a
// request carries m_tlast. Pairs leave at one per cycle while m_tready allows: the phase
// sequencer takes one step per pair, a start request occupies it without a pair, and
// requests run back to back out of a two-entry command queue, so the sequencer is the only
// rate limit. After the sequencer steps, a pair passes the phase register, the table read
// and the scaling into the output register, then appears on m_tdata. A stall on m_tready
// freezes the sequencer and table pipeline; the front keeps taking requests until the queue
// is full. Configuration is to be written only while idle; the block does not enforce it.

module fm_iq_modulator
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [23:0]                           s_tdata,   // [17:0] audio_sample
    input  logic [1:0]                            s_tuser,   // [1:0] req_type
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [15:0]                           m_tdata,   // [7:0] i_value, [15:8] q_value
    output logic                                  m_tlast,
    input  logic                                  cfg_we,
    input  logic [fmiq_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [fmiq_pkg::CFG_W-1:0]            cfg_data
);

    logic [fmiq_pkg::GAIN_W-1:0]      phase_gain_reg;
    logic [fmiq_pkg::AMP_W-1:0]       amplitude_reg;
    logic [fmiq_pkg::COUNT_W-1:0]     interp_ratio_reg;

    logic                             q_push;
    logic                             q_pop;
    logic                             q_full;
    logic                             q_not_empty;
    fmiq_pkg::cmd_t                   q_in;
    fmiq_pkg::cmd_t                   q_out;
    logic [fmiq_pkg::QLEVEL_W-1:0]    q_level;
    fmiq_pkg::back_status_t           back_status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_gain_reg   <= fmiq_pkg::PHASE_GAIN_RST;
            amplitude_reg    <= fmiq_pkg::AMPLITUDE_RST;
            interp_ratio_reg <= fmiq_pkg::INTERP_RATIO_RST;
        end
        else if (cfg_we)
        begin
            case (fmiq_pkg::cfg_index_t'(cfg_addr))
                fmiq_pkg::CFG_PHASE_GAIN:
                    phase_gain_reg <= cfg_data[fmiq_pkg::GAIN_W-1:0];
                fmiq_pkg::CFG_AMPLITUDE:
                    amplitude_reg <= cfg_data[fmiq_pkg::AMP_W-1:0];
                fmiq_pkg::CFG_INTERP_RATIO:
                    interp_ratio_reg <= cfg_data[fmiq_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    fmiq_front u_front
    (
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .phase_gain   (phase_gain_reg),
        .interp_ratio (interp_ratio_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (q_in)
    );

    fmiq_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .entry_in  (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .entry_out (q_out),
        .level     (q_level)
    );

    fmiq_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_entry   (q_out),
        .q_pop     (q_pop),
        .amplitude (amplitude_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .status    (back_status)
    );

    // a known request taken in leaves the queue holding at least one command
    a_request_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready &&
         (s_tuser == fmiq_pkg::REQ_START || s_tuser == fmiq_pkg::REQ_SILENCE ||
          s_tuser == fmiq_pkg::REQ_AUDIO))
        |=> (q_level != '0))
        else $error("request accepted but queue empty");

    // a stalled output freezes the phase sequencer
    a_stall_freezes_sequencer: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(back_status))
        else $error("sequencer moved during output stall");

endmodule
